/* hdl/assert_macros.svh */
// Concurrent assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/rdq_pkg.sv */
// Shared types and constants of the reversible deque.
package rdq_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int DATA_W      = 64;
    localparam int MODE_W      = 3;
    localparam int COUNT_OUT_W = 9;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_LEFT  = 3'd0,
        MODE_PUSH_RIGHT = 3'd1,
        MODE_POP_LEFT   = 3'd2,
        MODE_POP_RIGHT  = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_QUERY      = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of one chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic append;
    } cell_ctl_t;

endpackage

/* hdl/rdq_cell.sv */
// One storage cell of a deque chain: shifts with its neighbors or takes an append.
module rdq_cell #(
    parameter int CNT_W = 9,
    parameter int INDEX = 0
) (
    input  logic                        aclk,
    input  rdq_pkg::cell_ctl_t          ctl,
    input  logic [CNT_W-1:0]            count,
    input  logic [rdq_pkg::DATA_W-1:0]  shift_in,
    input  logic [rdq_pkg::DATA_W-1:0]  pull_in,
    input  logic [rdq_pkg::DATA_W-1:0]  value,
    output logic [rdq_pkg::DATA_W-1:0]  data
);

    logic [rdq_pkg::DATA_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            data_reg <= shift_in;
        end else if (ctl.pop) begin
            data_reg <= pull_in;
        end else if (ctl.append && (count == CNT_W'(INDEX))) begin
            data_reg <= value;
        end
    end

    assign data = data_reg;

endmodule

/* hdl/rdq_chain.sv */
// A row of cells holding the deque with its near end at cell zero.
module rdq_chain #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  rdq_pkg::cell_ctl_t          ctl,
    input  logic [CNT_W-1:0]            count,
    input  logic [rdq_pkg::DATA_W-1:0]  value,
    output logic [rdq_pkg::DATA_W-1:0]  head
);

    logic [rdq_pkg::DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [rdq_pkg::DATA_W-1:0] shift_src;
        logic [rdq_pkg::DATA_W-1:0] pull_src;

        if (i == 0) begin : g_first
            assign shift_src = value;
        end else begin : g_inner_left
            assign shift_src = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign pull_src = cell_data[i];
        end else begin : g_inner_right
            assign pull_src = cell_data[i+1];
        end

        rdq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .count    (count),
            .shift_in (shift_src),
            .pull_in  (pull_src),
            .value    (value),
            .data     (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

/* hdl/reversible_deque_core.sv */
// Reversible bounded deque: two mirrored cell chains, one headed at each end.
// A result is registered in the s1 stage, then loaded into the output registers once they are free.
// Throughput: one item per cycle unless the output stalls; each push or pop is one shift step.
// Each chain keeps a full copy, so both end values sit at fixed cells.
// Reset clears the count, the reverse flag and the handshake state; no clearing pass.
`include "assert_macros.svh"

module reversible_deque_core #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [rdq_pkg::MODE_W-1:0]              s_mode,
    input  logic signed [rdq_pkg::DATA_W-1:0]       s_push_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [rdq_pkg::DATA_W-1:0]       m_popped_value,
    output logic signed [rdq_pkg::DATA_W-1:0]       m_left_value,
    output logic signed [rdq_pkg::DATA_W-1:0]       m_right_value,
    output logic [rdq_pkg::COUNT_OUT_W-1:0]         m_element_count,
    output logic                                    m_is_empty,
    output logic [rdq_pkg::STATUS_W-1:0]            m_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          rev_reg;
    logic                          rev_next;
    logic                          s1_valid_reg;
    logic [rdq_pkg::DATA_W-1:0]    s1_popped_reg;
    logic [rdq_pkg::DATA_W-1:0]    popped_next;
    rdq_pkg::status_t              s1_status_reg;
    rdq_pkg::status_t              status_next;
    logic                          m_valid_reg;
    logic [rdq_pkg::DATA_W-1:0]    m_popped_reg;
    logic [rdq_pkg::DATA_W-1:0]    m_left_reg;
    logic [rdq_pkg::DATA_W-1:0]    m_right_reg;
    logic [rdq_pkg::COUNT_OUT_W-1:0] m_count_reg;
    logic                          m_empty_reg;
    rdq_pkg::status_t              m_status_reg;

    rdq_pkg::cell_ctl_t            l_ctl;
    rdq_pkg::cell_ctl_t            r_ctl;
    logic [rdq_pkg::DATA_W-1:0]    l_head;
    logic [rdq_pkg::DATA_W-1:0]    r_head;
    logic [rdq_pkg::DATA_W-1:0]    push_data;
    logic                          s_fire;
    logic                          out_load;
    logic                          full;
    logic                          empty;
    logic                          want_left;
    logic                          phys_left;

    assign push_data = rdq_pkg::DATA_W'(s_push_value);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign out_load  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign want_left = (s_mode == rdq_pkg::MODE_PUSH_LEFT)
                    || (s_mode == rdq_pkg::MODE_POP_LEFT);
    assign phys_left = want_left ^ rev_reg;

    always_comb begin
        l_ctl       = '0;
        r_ctl       = '0;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = rdq_pkg::ST_OK;
        popped_next = '0;
        if (s_fire) begin
            unique case (s_mode) inside
                rdq_pkg::MODE_PUSH_LEFT, rdq_pkg::MODE_PUSH_RIGHT: begin
                    if (full) begin
                        status_next = rdq_pkg::ST_PUSH_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        if (phys_left) begin
                            l_ctl.push   = 1'b1;
                            r_ctl.append = 1'b1;
                        end else begin
                            r_ctl.push   = 1'b1;
                            l_ctl.append = 1'b1;
                        end
                    end
                end
                rdq_pkg::MODE_POP_LEFT, rdq_pkg::MODE_POP_RIGHT: begin
                    if (empty) begin
                        status_next = rdq_pkg::ST_POP_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        if (phys_left) begin
                            l_ctl.pop   = 1'b1;
                            popped_next = l_head;
                        end else begin
                            r_ctl.pop   = 1'b1;
                            popped_next = r_head;
                        end
                    end
                end
                rdq_pkg::MODE_REVERSE: begin
                    rev_next = !rev_reg;
                end
                default: begin
                end
            endcase
        end
    end

    rdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_left_chain (
        .aclk  (aclk),
        .ctl   (l_ctl),
        .count (count_reg),
        .value (push_data),
        .head  (l_head)
    );

    rdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_right_chain (
        .aclk  (aclk),
        .ctl   (r_ctl),
        .count (count_reg),
        .value (push_data),
        .head  (r_head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rev_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_popped_reg <= popped_next;
            s1_status_reg <= status_next;
        end
        if (out_load) begin
            m_popped_reg <= s1_popped_reg;
            m_left_reg   <= empty ? '0 : (rev_reg ? r_head : l_head);
            m_right_reg  <= empty ? '0 : (rev_reg ? l_head : r_head);
            m_count_reg  <= rdq_pkg::COUNT_OUT_W'(count_reg);
            m_empty_reg  <= empty;
            m_status_reg <= s1_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_popped_value  = m_popped_reg;
    assign m_left_value    = m_left_reg;
    assign m_right_value   = m_right_reg;
    assign m_element_count = m_count_reg;
    assign m_is_empty      = m_empty_reg;
    assign m_status        = m_status_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn,
        count_reg <= CNT_W'(DEPTH), "count exceeds depth")
    `ASSERT_IMPLY(a_empty_ends_zero, aclk, aresetn, m_valid && m_is_empty,
        (m_left_value == '0) && (m_right_value == '0), "empty result shows nonzero ends")
    `ASSERT_IMPLY(a_failed_pop_zero, aclk, aresetn,
        m_valid && (m_status == rdq_pkg::ST_POP_EMPTY),
        m_popped_value == '0, "failed pop returns a value")
    `ASSERT_NEXT(a_full_push_holds, aclk, aresetn,
        s_fire && full && ((s_mode == rdq_pkg::MODE_PUSH_LEFT)
                           || (s_mode == rdq_pkg::MODE_PUSH_RIGHT)),
        $stable(count_reg), "push on full changed the count")

endmodule
